FILE: design/sarc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sarc_pkg
// Shared constants and types for the summed-area rectangle counter.
// ----------------------------------------------------------------------------
package sarc_pkg;

    // Field widths fixed by the item formats.
    localparam int ENTRY_W   = 15;
    localparam int SUM_W     = 8;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CORNER_W  = 7;

    // Default grid limits.
    localparam int DEF_MAX_ROWS = 128;
    localparam int DEF_MAX_COLS = 128;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
    localparam logic [CFG_W-1:0]     ROWS_RESET = 8'd128;
    localparam logic [CFG_W-1:0]     COLS_RESET = 8'd128;

    // Per-cell load information handed from the load sequencer to the top.
    typedef struct packed {
        logic             above_zero;
        logic [SUM_W-1:0] sum;
    } t_load_flags;

endpackage
`default_nettype wire

FILE: design/sarc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sarc_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module sarc_ram #(
    parameter int WIDTH = sarc_pkg::ENTRY_W,
    parameter int DEPTH = sarc_pkg::DEF_MAX_ROWS * sarc_pkg::DEF_MAX_COLS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic                     i_re_b,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds while its port is not enabled.
        if (i_re_a) begin
            o_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule
`default_nettype wire

FILE: design/sarc_load_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sarc_load_seq
// Load position, running row sum and table-ready flag for the grid build.
// ----------------------------------------------------------------------------
module sarc_load_seq #(
    parameter int MAX_ROWS = sarc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = sarc_pkg::DEF_MAX_COLS,
    localparam int RW  = $clog2(MAX_ROWS),
    localparam int CW  = $clog2(MAX_COLS),
    localparam int DRW = $clog2(MAX_ROWS + 1),
    localparam int DCW = $clog2(MAX_COLS + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_restart,
    input  wire logic                  i_step,
    input  wire logic                  i_cell_marked,
    input  wire logic [DRW-1:0]        i_rows,
    input  wire logic [DCW-1:0]        i_cols,
    output logic      [RW-1:0]         o_row,
    output logic      [CW-1:0]         o_col,
    output sarc_pkg::t_load_flags      o_flags,
    output logic                       o_grid_ready
);

    logic [RW-1:0]              r_row, n_row;
    logic [CW-1:0]              r_col, n_col;
    logic [sarc_pkg::SUM_W-1:0] r_sum, n_sum;
    logic                       r_ready, n_ready;

    logic                       wrap;
    logic [RW-1:0]              eff_row;
    logic [CW-1:0]              eff_col;
    logic [sarc_pkg::SUM_W-1:0] base_sum;
    logic [sarc_pkg::SUM_W-1:0] step_sum;
    logic [31:0]                row_inc;
    logic [31:0]                col_inc;

    always_comb begin
        // A finished grid, or a position left outside a shrunken grid, starts over.
        wrap = r_ready || (32'(r_row) >= 32'(i_rows)) || (32'(r_col) >= 32'(i_cols));
        eff_row  = wrap ? '0 : r_row;
        eff_col  = wrap ? '0 : r_col;
        base_sum = wrap ? '0 : r_sum;
        step_sum = base_sum + sarc_pkg::SUM_W'(i_cell_marked);
        row_inc  = 32'(eff_row) + 32'd1;
        col_inc  = 32'(eff_col) + 32'd1;

        n_row   = r_row;
        n_col   = r_col;
        n_sum   = r_sum;
        n_ready = r_ready;
        if (i_restart) begin
            n_row   = '0;
            n_col   = '0;
            n_sum   = '0;
            n_ready = 1'b0;
        end else if (i_step) begin
            if (col_inc >= 32'(i_cols)) begin
                n_col = '0;
                n_sum = '0;
                if (row_inc >= 32'(i_rows)) begin
                    n_row   = '0;
                    n_ready = 1'b1;
                end else begin
                    n_row   = row_inc[RW-1:0];
                    n_ready = 1'b0;
                end
            end else begin
                n_col   = col_inc[CW-1:0];
                n_sum   = step_sum;
                n_row   = eff_row;
                n_ready = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_sum   <= '0;
            r_ready <= 1'b0;
        end else begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_sum   <= n_sum;
            r_ready <= n_ready;
        end
    end

    assign o_row              = eff_row;
    assign o_col              = eff_col;
    assign o_flags.above_zero = (eff_row == '0);
    assign o_flags.sum        = step_sum;
    assign o_grid_ready       = r_ready;

endmodule
`default_nettype wire

FILE: design/summed_area_rectangle_count.sv
`default_nettype none
// ----------------------------------------------------------------------------
// summed_area_rectangle_count
// Builds a summed-area table from a binary grid and counts marked cells in
// rectangles.
// ----------------------------------------------------------------------------
// Load transactions (mode 0) deliver the grid one cell at a time in row-major
// order; each one reads the table entry above it from the memory and writes
// the new entry back on the following cycle, and produces no result. Once the
// last cell of the configured grid has loaded, query transactions (mode 1)
// return the count of marked cells in the inclusive rectangle spanned by two
// corners given in any order. A query reads four table entries as two pairs on
// the two read ports of the table memory, the first pair as it is accepted and
// the second in state Q1; in state Q2 the result is written to the output
// register, and when that register is free a new transaction may be accepted
// in that same cycle. A query before the table is ready, or with a corner
// outside the configured grid, returns a count of zero with query_ok low.
// Writing either dimension register restarts the build. The table memory
// needs no clearing pass after reset, as every entry is written before any
// query may read it.
// ----------------------------------------------------------------------------
module summed_area_rectangle_count #(
    parameter int MAX_ROWS = sarc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = sarc_pkg::DEF_MAX_COLS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port.
    input  wire logic                              i_cfg_we,
    input  wire logic [sarc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sarc_pkg::CFG_W-1:0]        i_cfg_data,
    // Input channel.
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_mode,
    input  wire logic                              i_cell_marked,
    input  wire logic [sarc_pkg::CORNER_W-1:0]     i_row_a,
    input  wire logic [sarc_pkg::CORNER_W-1:0]     i_col_a,
    input  wire logic [sarc_pkg::CORNER_W-1:0]     i_row_b,
    input  wire logic [sarc_pkg::CORNER_W-1:0]     i_col_b,
    // Output channel.
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic      [sarc_pkg::ENTRY_W-1:0]      o_marked_count,
    output logic                                   o_query_ok
);

    // The table is addressed as {row, column}, so each row occupies a
    // power-of-two slot of columns.
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int DRW   = $clog2(MAX_ROWS + 1);
    localparam int DCW   = $clog2(MAX_COLS + 1);
    localparam int AW    = RW + CW;
    localparam int DEPTH = MAX_ROWS * (2 ** CW);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a transaction
    localparam logic [1:0] ST_LWR  = 2'd1;  // load: write the new entry back
    localparam logic [1:0] ST_Q1   = 2'd2;  // query: second pair of reads
    localparam logic [1:0] ST_Q2   = 2'd3;  // query: combine and deliver

    // ------------------------------------------------------------------------
    // Configuration registers and clamped grid dimensions.
    // ------------------------------------------------------------------------
    logic [sarc_pkg::CFG_W-1:0] r_rows_cfg;
    logic [sarc_pkg::CFG_W-1:0] r_cols_cfg;
    logic                       cfg_restart;
    logic [31:0]                rows_tmp;
    logic [31:0]                cols_tmp;
    logic [DRW-1:0]             rows_eff;
    logic [DCW-1:0]             cols_eff;

    assign cfg_restart = i_cfg_we &&
                         (i_cfg_index == sarc_pkg::REG_ROWS ||
                          i_cfg_index == sarc_pkg::REG_COLS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= sarc_pkg::ROWS_RESET;
            r_cols_cfg <= sarc_pkg::COLS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == sarc_pkg::REG_ROWS) begin
                r_rows_cfg <= i_cfg_data;
            end
            if (i_cfg_index == sarc_pkg::REG_COLS) begin
                r_cols_cfg <= i_cfg_data;
            end
        end
    end

    // A dimension of zero behaves as one; anything above the limit is held to it.
    always_comb begin
        rows_tmp = 32'(r_rows_cfg);
        if (r_rows_cfg == '0) begin
            rows_tmp = 32'd1;
        end else if (rows_tmp > 32'(MAX_ROWS)) begin
            rows_tmp = 32'(MAX_ROWS);
        end
        cols_tmp = 32'(r_cols_cfg);
        if (r_cols_cfg == '0) begin
            cols_tmp = 32'd1;
        end else if (cols_tmp > 32'(MAX_COLS)) begin
            cols_tmp = 32'(MAX_COLS);
        end
        rows_eff = rows_tmp[DRW-1:0];
        cols_eff = cols_tmp[DCW-1:0];
    end

    // ------------------------------------------------------------------------
    // Handshake and sequencer.
    // ------------------------------------------------------------------------
    logic [1:0] r_state, n_state;
    logic       out_free;
    logic       accept;
    logic       acc_load;
    logic       acc_query;

    // The output register can take a result when it is empty or being drained.
    assign out_free  = !o_valid || !i_stall;
    assign o_stall   = !((r_state == ST_IDLE) || (r_state == ST_Q2 && out_free));
    assign accept    = i_valid && !o_stall;
    assign acc_load  = accept && !i_mode;
    assign acc_query = accept && i_mode;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc_load) begin
                    n_state = ST_LWR;
                end else if (acc_query) begin
                    n_state = ST_Q1;
                end
            end
            ST_LWR: begin
                n_state = ST_IDLE;
            end
            ST_Q1: begin
                n_state = ST_Q2;
            end
            ST_Q2: begin
                // Finishing a query and taking the next transaction overlap.
                if (out_free) begin
                    if (acc_load) begin
                        n_state = ST_LWR;
                    end else if (acc_query) begin
                        n_state = ST_Q1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------------
    // Load position tracking.
    // ------------------------------------------------------------------------
    logic [RW-1:0]         ld_row;
    logic [CW-1:0]         ld_col;
    sarc_pkg::t_load_flags ld_flags;
    logic                  grid_ready;

    sarc_load_seq #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_load_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (cfg_restart),
        .i_step        (acc_load),
        .i_cell_marked (i_cell_marked),
        .i_rows        (rows_eff),
        .i_cols        (cols_eff),
        .o_row         (ld_row),
        .o_col         (ld_col),
        .o_flags       (ld_flags),
        .o_grid_ready  (grid_ready)
    );

    // The pending write of a load is held here until the entry above returns.
    logic [AW-1:0]              r_waddr;
    logic                       r_above_zero;
    logic [sarc_pkg::SUM_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (acc_load) begin
            r_waddr      <= {ld_row, ld_col};
            r_above_zero <= ld_flags.above_zero;
            r_sum        <= ld_flags.sum;
        end
    end

    // ------------------------------------------------------------------------
    // Query corner normalisation and range check.
    // ------------------------------------------------------------------------
    logic [sarc_pkg::CORNER_W-1:0] q_r1, q_r2, q_c1, q_c2;
    logic                          q_ok;
    logic [31:0]                   row_hi_w, row_lo_w, col_hi_w, col_lo_w;
    logic [RW-1:0]                 q_row_hi, q_row_lo;
    logic [CW-1:0]                 q_col_hi, q_col_lo;

    always_comb begin
        q_r1 = (i_row_a > i_row_b) ? i_row_b : i_row_a;
        q_r2 = (i_row_a > i_row_b) ? i_row_a : i_row_b;
        q_c1 = (i_col_a > i_col_b) ? i_col_b : i_col_a;
        q_c2 = (i_col_a > i_col_b) ? i_col_a : i_col_b;
        q_ok = grid_ready && (32'(q_r2) < 32'(rows_eff)) && (32'(q_c2) < 32'(cols_eff));
        // The corner just outside the rectangle sits one row up and one column
        // left; when that falls off the grid its term is zero.
        row_hi_w = 32'(q_r2);
        row_lo_w = 32'(q_r1) - 32'd1;
        col_hi_w = 32'(q_c2);
        col_lo_w = 32'(q_c1) - 32'd1;
        q_row_hi = row_hi_w[RW-1:0];
        q_row_lo = row_lo_w[RW-1:0];
        q_col_hi = col_hi_w[CW-1:0];
        q_col_lo = col_lo_w[CW-1:0];
    end

    logic [RW-1:0] r_row_hi, r_row_lo;
    logic [CW-1:0] r_col_lo;
    logic          r_ok;
    logic          r_b_zero, r_c_zero, r_d_zero;

    always_ff @(posedge i_clk) begin
        if (acc_query) begin
            r_row_hi <= q_row_hi;
            r_row_lo <= q_row_lo;
            r_col_lo <= q_col_lo;
            r_ok     <= q_ok;
            r_b_zero <= (q_r1 == '0);
            r_c_zero <= (q_c1 == '0);
            r_d_zero <= (q_r1 == '0) || (q_c1 == '0);
        end
    end

    // ------------------------------------------------------------------------
    // Table memory.
    // ------------------------------------------------------------------------
    logic                         ram_we;
    logic [sarc_pkg::ENTRY_W-1:0] ram_wdata;
    logic                         re_a, re_b;
    logic [AW-1:0]                raddr_a, raddr_b;
    logic [sarc_pkg::ENTRY_W-1:0] rdata_a, rdata_b;

    // Reads and writes never share a cycle: the write cycle of a load stalls input.
    always_comb begin
        re_a    = 1'b0;
        re_b    = 1'b0;
        raddr_a = '0;
        raddr_b = '0;
        if (acc_load) begin
            re_a    = 1'b1;
            raddr_a = {ld_row - RW'(1), ld_col};
        end else if (acc_query) begin
            re_a    = 1'b1;
            re_b    = 1'b1;
            raddr_a = {q_row_hi, q_col_hi};
            raddr_b = {q_row_lo, q_col_hi};
        end else if (r_state == ST_Q1) begin
            re_a    = 1'b1;
            re_b    = 1'b1;
            raddr_a = {r_row_hi, r_col_lo};
            raddr_b = {r_row_lo, r_col_lo};
        end
    end

    assign ram_we    = (r_state == ST_LWR);
    assign ram_wdata = (r_above_zero ? '0 : rdata_a) + sarc_pkg::ENTRY_W'(r_sum);

    sarc_ram #(
        .WIDTH (sarc_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (r_waddr),
        .i_wdata   (ram_wdata),
        .i_re_a    (re_a),
        .i_raddr_a (raddr_a),
        .o_rdata_a (rdata_a),
        .i_re_b    (re_b),
        .i_raddr_b (raddr_b),
        .o_rdata_b (rdata_b)
    );

    // ------------------------------------------------------------------------
    // Query arithmetic and output register.
    // ------------------------------------------------------------------------
    logic [sarc_pkg::ENTRY_W-1:0] r_ta, r_tb;
    logic [sarc_pkg::ENTRY_W-1:0] tc, td, q_sum;

    // The first pair of entries is captured while the second pair is read; the
    // read data registers keep the second pair steady while the output waits.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_Q1) begin
            r_ta <= rdata_a;
            r_tb <= r_b_zero ? '0 : rdata_b;
        end
    end

    assign tc    = r_c_zero ? '0 : rdata_a;
    assign td    = r_d_zero ? '0 : rdata_b;
    assign q_sum = r_ta - r_tb - tc + td;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (r_state == ST_Q2 && out_free) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_Q2 && out_free) begin
            o_marked_count <= r_ok ? q_sum : '0;
            o_query_ok     <= r_ok;
        end
    end

`ifndef SYNTHESIS
    // A failed query always reports a count of zero.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_query_ok) |-> (o_marked_count == '0))
        else $error("failed query carries a non-zero count");

    // A load holds off the next transaction while it writes its entry back.
    a_load_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_mode) |=> o_stall)
        else $error("transaction accepted during load write-back");

    // A dimension write discards any finished table.
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_index == sarc_pkg::REG_ROWS ||
                      i_cfg_index == sarc_pkg::REG_COLS)) |=> !grid_ready)
        else $error("table still marked ready after a dimension write");
`endif

endmodule
`default_nettype wire

FILE: sim/summed_area_rectangle_count_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// summed_area_rectangle_count_tb
// Self-checking testbench for the summed-area rectangle counter.
// ----------------------------------------------------------------------------
// Grids are loaded cell by cell and then queried with random and hand-picked
// rectangles. A behavioural copy of the summed-area table runs beside the
// block. It is updated from the transactions seen on the ports, and each query
// it sees pushes the count it expects. Results are compared field by field, in
// order, as they leave the block. Sender gaps and receiver stalls are varied
// over several phases. One phase holds the output off for a long stretch so
// that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module summed_area_rectangle_count_tb;

    localparam int GRID_ROWS     = sarc_pkg::DEF_MAX_ROWS;
    localparam int GRID_COLS     = sarc_pkg::DEF_MAX_COLS;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ERRORS_SHOWN  = 10;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [sarc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd2;

    typedef struct packed {
        logic [sarc_pkg::ENTRY_W-1:0] count;
        logic                         ok;
    } t_rect_count;

    // Every input of the block starts at a known value.
    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [sarc_pkg::CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [sarc_pkg::CFG_W-1:0]     i_cfg_data    = '0;
    logic                           i_valid       = 1'b0;
    logic                           i_mode        = MODE_LOAD;
    logic                           i_cell_marked = 1'b0;
    logic [sarc_pkg::CORNER_W-1:0]  i_row_a       = '0;
    logic [sarc_pkg::CORNER_W-1:0]  i_col_a       = '0;
    logic [sarc_pkg::CORNER_W-1:0]  i_row_b       = '0;
    logic [sarc_pkg::CORNER_W-1:0]  i_col_b       = '0;
    logic                           i_stall       = 1'b0;
    logic                           o_stall;
    logic                           o_valid;
    logic [sarc_pkg::ENTRY_W-1:0]   o_marked_count;
    logic                           o_query_ok;

    summed_area_rectangle_count dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_cell_marked  (i_cell_marked),
        .i_row_a        (i_row_a),
        .i_col_a        (i_col_a),
        .i_row_b        (i_row_b),
        .i_col_b        (i_col_b),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_marked_count (o_marked_count),
        .o_query_ok     (o_query_ok)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioural summed-area table. It holds its own copy of the dimension
    // registers and of the load position, and is advanced only from what is
    // seen at the ports on each rising edge.
    // ------------------------------------------------------------------------
    bit [sarc_pkg::ENTRY_W-1:0] sat_entries [0:GRID_ROWS-1][0:GRID_COLS-1];
    logic [sarc_pkg::CFG_W-1:0] rows_reg;
    logic [sarc_pkg::CFG_W-1:0] cols_reg;
    logic [sarc_pkg::SUM_W-1:0] run_sum;
    int                         load_r;
    int                         load_c;
    bit                         grid_ready;

    t_rect_count pending_counts [$];

    int cycle_count  = 0;
    int errors       = 0;
    int items_sent   = 0;
    int n_loads      = 0;
    int n_queries    = 0;
    int n_in_range   = 0;
    int n_dim_writes = 0;

    // Idling controls, changed per phase by the test sequence.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;

    // A register value of zero behaves as one; anything above the limit
    // behaves as the limit.
    function automatic int eff_dim(input logic [sarc_pkg::CFG_W-1:0] v, input int lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic int grid_rows();
        return eff_dim(rows_reg, GRID_ROWS);
    endfunction

    function automatic int grid_cols();
        return eff_dim(cols_reg, GRID_COLS);
    endfunction

    function automatic void restart_build();
        run_sum    = '0;
        load_r     = 0;
        load_c     = 0;
        grid_ready = 1'b0;
    endfunction

    function automatic void reset_predictor();
        rows_reg = sarc_pkg::ROWS_RESET;
        cols_reg = sarc_pkg::COLS_RESET;
        restart_build();
        pending_counts.delete();
    endfunction

    // Sum of the cells in rows [0, r) and columns [0, c).
    function automatic int corner_sum(input int r, input int c);
        if (r == 0 || c == 0) return 0;
        return sat_entries[r-1][c-1];
    endfunction

    function automatic void apply_dim_write(input logic [sarc_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [sarc_pkg::CFG_W-1:0] data);
        if (idx == sarc_pkg::REG_ROWS) begin
            rows_reg = data;
        end else if (idx == sarc_pkg::REG_COLS) begin
            cols_reg = data;
        end else begin
            return;
        end
        n_dim_writes++;
        restart_build();
    endfunction

    function automatic void apply_cell_load(input logic marked);
        int nr;
        int nc;
        nr = grid_rows();
        nc = grid_cols();
        if (grid_ready) restart_build();
        if (load_r >= nr || load_c >= nc) restart_build();
        run_sum = run_sum + sarc_pkg::SUM_W'(marked);
        sat_entries[load_r][load_c] =
            sarc_pkg::ENTRY_W'(corner_sum(load_r, load_c + 1) + run_sum);
        load_c++;
        if (load_c >= nc) begin
            load_c  = 0;
            run_sum = '0;
            load_r++;
            if (load_r >= nr) begin
                load_r     = 0;
                grid_ready = 1'b1;
            end
        end
    endfunction

    function automatic t_rect_count predict_rect_count(input int ra, input int ca,
                                                       input int rb, input int cb);
        t_rect_count res;
        int r1;
        int r2;
        int c1;
        int c2;
        int s;
        r1 = (ra < rb) ? ra : rb;
        r2 = (ra < rb) ? rb : ra;
        c1 = (ca < cb) ? ca : cb;
        c2 = (ca < cb) ? cb : ca;
        res = '0;
        if (grid_ready && r2 < grid_rows() && c2 < grid_cols()) begin
            s = corner_sum(r2 + 1, c2 + 1) - corner_sum(r1, c2 + 1)
              - corner_sum(r2 + 1, c1) + corner_sum(r1, c1);
            res.count = s[sarc_pkg::ENTRY_W-1:0];
            res.ok    = 1'b1;
        end
        return res;
    endfunction

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= ERRORS_SHOWN) $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endfunction

    // Register writes and accepted input transactions advance the table copy;
    // every query leaves one expected count behind.
    function automatic void track_inputs();
        if (i_cfg_we) apply_dim_write(i_cfg_index, i_cfg_data);
        if (i_valid && !o_stall) begin
            if (i_mode == MODE_QUERY) begin
                pending_counts.push_back(predict_rect_count(i_row_a, i_col_a,
                                                            i_row_b, i_col_b));
                n_queries++;
                if (pending_counts[$].ok) n_in_range++;
            end else begin
                apply_cell_load(i_cell_marked);
                n_loads++;
            end
        end
    endfunction

    function automatic void check_output();
        t_rect_count want;
        if (!(o_valid && !i_stall)) return;
        if (pending_counts.size() == 0) begin
            note_error($sformatf("result with no query outstanding: count %0d ok %0b",
                                 o_marked_count, o_query_ok));
            return;
        end
        want = pending_counts.pop_front();
        if (o_marked_count !== want.count)
            note_error($sformatf("marked_count: expected %0d, got %0d",
                                 want.count, o_marked_count));
        if (o_query_ok !== want.ok)
            note_error($sformatf("query_ok: expected %0b, got %0b", want.ok, o_query_ok));
    endfunction

    // Everything is sampled at the rising edge, where the values seen are
    // those settled since the previous falling edge.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     pending_counts.size());
            $display("*** FAILED ***");
            $finish;
        end else if (!i_rst_n) begin
            reset_predictor();
        end else begin
            track_inputs();
            check_output();
        end
    end

    // Receiver side. A requested hold-off is counted down here, cycle by
    // cycle; otherwise the output stalls at the rate of the current phase.
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else begin
            i_stall = ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sender side. Every task below is entered and left just after a falling
    // edge, so inputs only ever change there. The valid line is left high on
    // return, so back-to-back transactions need no gap; whatever does not send
    // next lowers it first.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic mode, input logic marked,
                             input logic [sarc_pkg::CORNER_W-1:0] ra,
                             input logic [sarc_pkg::CORNER_W-1:0] ca,
                             input logic [sarc_pkg::CORNER_W-1:0] rb,
                             input logic [sarc_pkg::CORNER_W-1:0] cb);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_mode        = mode;
        i_cell_marked = marked;
        i_row_a       = ra;
        i_col_a       = ca;
        i_row_b       = rb;
        i_col_b       = cb;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // The fields a transaction does not use carry random values, since the
    // block must ignore them.
    task automatic send_load(input logic marked);
        send_item(MODE_LOAD, marked,
                  sarc_pkg::CORNER_W'($urandom_range(0, 127)),
                  sarc_pkg::CORNER_W'($urandom_range(0, 127)),
                  sarc_pkg::CORNER_W'($urandom_range(0, 127)),
                  sarc_pkg::CORNER_W'($urandom_range(0, 127)));
    endtask

    task automatic send_query(input int ra, input int ca, input int rb, input int cb);
        send_item(MODE_QUERY, 1'($urandom_range(0, 1)),
                  sarc_pkg::CORNER_W'(ra), sarc_pkg::CORNER_W'(ca),
                  sarc_pkg::CORNER_W'(rb), sarc_pkg::CORNER_W'(cb));
    endtask

    task automatic send_random_query(input int in_range_pct);
        int nr;
        int nc;
        nr = grid_rows();
        nc = grid_cols();
        if ($urandom_range(0, 99) < in_range_pct) begin
            send_query($urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                       $urandom_range(0, nr - 1), $urandom_range(0, nc - 1));
        end else begin
            send_query($urandom_range(0, 127), $urandom_range(0, 127),
                       $urandom_range(0, 127), $urandom_range(0, 127));
        end
    endtask

    // Pause the sender until every result is back. A load leaves no result,
    // so a few extra cycles let the last table write finish too.
    task automatic wait_idle();
        i_valid = 1'b0;
        while (pending_counts.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [sarc_pkg::CFG_IDX_W-1:0] idx, input int data);
        wait_idle();
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = sarc_pkg::CFG_W'(data);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic set_dims(input int rows_v, input int cols_v);
        write_reg(sarc_pkg::REG_ROWS, rows_v);
        write_reg(sarc_pkg::REG_COLS, cols_v);
    endtask

    // Loads a whole grid for the current dimensions. A query slipped in after
    // any load but the last must come back as not ready.
    task automatic build_grid(input int marked_pct, input int stray_query_pct);
        int n;
        n = grid_rows() * grid_cols();
        for (int k = 0; k < n; k++) begin
            send_load($urandom_range(0, 99) < marked_pct);
            if ($urandom_range(0, 99) < stray_query_pct) send_random_query(50);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // After reset the dimensions are at their maximum and no table exists, so
    // every query, even one spanning the whole grid, must come back not ok.
    task automatic test_before_ready();
        send_query(0, 0, 127, 127);
        send_query(127, 127, 0, 0);
        wait_idle();
    endtask

    // A two by three grid with a known pattern, queried with swapped corners,
    // a single cell, and corners just outside the grid in each direction.
    task automatic test_small_grid();
        logic [5:0] pattern;
        pattern = 6'b011101;
        set_dims(2, 3);
        for (int k = 0; k < 6; k++) send_load(pattern[k]);
        send_query(1, 2, 0, 0);
        send_query(0, 0, 1, 2);
        send_query(1, 1, 1, 1);
        send_query(0, 2, 1, 0);
        send_query(1, 0, 0, 2);
        send_query(2, 0, 0, 0);
        send_query(0, 3, 0, 0);
        send_query(127, 127, 127, 127);
        wait_idle();
    endtask

    // A load once the grid is ready throws the table away and starts a new
    // grid at the first cell; queries fail until that grid is complete.
    task automatic test_load_after_ready();
        send_load(1'b1);
        send_query(0, 0, 1, 2);
        for (int k = 0; k < 5; k++) send_load(1'($urandom_range(0, 1)));
        send_query(0, 0, 1, 2);
        wait_idle();
    endtask

    // A dimension write part-way through a build restarts it. A write to an
    // index with no register behind it leaves a ready table alone.
    task automatic test_restart_on_write();
        set_dims(3, 3);
        for (int k = 0; k < 5; k++) send_load(1'b1);
        write_reg(sarc_pkg::REG_ROWS, 3);
        send_query(0, 0, 2, 2);
        build_grid(50, 0);
        send_query(2, 2, 0, 0);
        write_reg(REG_SPARE, 8'hA5);
        send_query(0, 0, 2, 2);
        wait_idle();
    endtask

    // Register values at and beyond both ends of their range, on grids that
    // are long and thin so that corner 127 is reachable cheaply.
    task automatic test_dimension_extremes();
        int dims [4][2];
        dims = '{'{0, 255}, '{255, 1}, '{128, 2}, '{1, 128}};
        for (int k = 0; k < 4; k++) begin
            set_dims(dims[k][0], dims[k][1]);
            build_grid((k == 0) ? 100 : 50, 0);
            send_query(0, 0, grid_rows() - 1, grid_cols() - 1);
            send_query(127, 127, 0, 0);
            repeat (8) send_random_query(75);
        end
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while queries keep coming,
    // so the block has to stall its input until the hold is released.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_dims(4, 5);
        build_grid(40, 0);
        hold_request = 300;
        repeat (64) send_random_query(90);
        wait_idle();
    endtask

    function automatic int pick_dim();
        int p;
        p = $urandom_range(0, 99);
        if (p < 5) return 0;
        if (p < 80) return $urandom_range(1, 6);
        return $urandom_range(7, 16);
    endfunction

    // Mostly well-formed traffic: a build at fresh dimensions followed by a
    // burst of queries. Now and then a query lands mid-build, or a stray load
    // breaks a finished grid of more than one cell so later queries fail.
    task automatic run_random_builds(input int n_items);
        int start;
        int marked_pct;
        int p;
        start = items_sent;
        while (items_sent - start < n_items) begin
            set_dims(pick_dim(), pick_dim());
            p = $urandom_range(0, 9);
            marked_pct = (p == 0) ? 0 : (p == 1) ? 100 : $urandom_range(0, 100);
            build_grid(marked_pct, 3);
            repeat ($urandom_range(4, 16)) begin
                if ($urandom_range(0, 99) < 2) send_load(1'($urandom_range(0, 1)));
                else send_random_query(80);
            end
        end
    endtask

    task automatic test_random_phases();
        int idle_pcts  [4];
        int stall_pcts [4];
        idle_pcts  = '{0, 74, 0, 6};
        stall_pcts = '{0, 0, 74, 6};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_pcts[ph];
            recv_stall_pct = stall_pcts[ph];
            run_random_builds(70);
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_before_ready();
        test_small_grid();
        test_load_after_ready();
        test_restart_on_write();
        test_dimension_extremes();
        test_backpressure();
        test_random_phases();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_idle();
        if (pending_counts.size() != 0)
            note_error($sformatf("%0d results never arrived", pending_counts.size()));

        $display("Covered %0d cell loads and %0d rectangle queries, %0d of them in range,",
                 n_loads, n_queries, n_in_range);
        $display("over %0d dimension writes, with idle, stall and hold-off phases; %0d errors.",
                 n_dim_writes, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
